// ----- rtl/bounded_deque_with_priority_push_macros.svh -----
// Assertion helpers for the checker file.
// Both sample on the rising edge of clock and are idle while reset is high.
`ifndef BOUNDED_DEQUE_WITH_PRIORITY_PUSH_MACROS_SVH
`define BOUNDED_DEQUE_WITH_PRIORITY_PUSH_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define BDQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/bdq_pkg.sv -----
`default_nettype none

package bdq_pkg;

   // Fixed field widths of the request and response items
   localparam int OP_W     = 3;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 8;
   localparam int CAP_W    = 8;

   // Packed bus widths, padded to whole bytes
   localparam int REQ_W = 40;
   localparam int RSP_W = 48;

   // Capacity after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 8'd100;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_QUERY      = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_REJECTED = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_EVICTED  = 2'd3
   } status_type;

   // One response item as produced by the engine
   typedef struct packed {
      logic               is_full;
      logic               is_empty;
      logic [COUNT_W-1:0] count;
      logic [DATA_W-1:0]  front_data;
      status_type         status;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/bdq_store.sv -----
`default_nettype none

// Ring storage: one write port, one registered read port.
// A write to the address being read in the same cycle is forwarded.
module bdq_store #(
   parameter int DEPTH      = 128,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [DATA_WIDTH-1:0]             wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [DATA_WIDTH-1:0]             rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_ff;
   logic                  byp_ff;
   logic [DATA_WIDTH-1:0] byp_data_ff;

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   // same-cycle write forwarding
   always_ff @(posedge clock) begin
      byp_ff      <= wr_en && (wr_addr == rd_addr);
      byp_data_ff <= wr_data;
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_ff;

endmodule

`default_nettype wire

// ----- rtl/bdq_engine.sv -----
`default_nettype none

// Deque state (front pointer, count, cached front word) and the
// next-state update for one operation.
module bdq_engine #(
   parameter int DEPTH      = 128,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          take,
   input  wire logic [bdq_pkg::OP_W-1:0]      op,
   input  wire logic [bdq_pkg::DATA_W-1:0]    data,
   input  wire logic [bdq_pkg::CAP_W-1:0]     capacity,
   output bdq_pkg::result_type                result
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [AW-1:0]         fp_ff, fp_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [DATA_WIDTH-1:0] front_ff, front_in;

   logic [CW-1:0]         limit;
   logic                  full;
   logic [DATA_WIDTH-1:0] word;
   logic [AW:0]           tail_sum;
   logic [AW-1:0]         tail_addr;
   logic [AW-1:0]         fp_dec;
   logic                  wr_req;
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0] next_word;
   bdq_pkg::status_type   status;

   function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
      logic [AW-1:0] r;
      if (p == AW'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + AW'(1);
      end
      return r;
   endfunction

   // effective capacity, clamped to 1 .. DEPTH
   always_comb begin
      if (capacity == '0) begin
         limit = CW'(1);
      end else if (32'(capacity) > 32'(DEPTH)) begin
         limit = CW'(DEPTH);
      end else begin
         limit = CW'(capacity);
      end
   end

   assign full = (count_ff >= limit);
   assign word = DATA_WIDTH'(data);

   // back slot and slot in front of the head
   assign tail_sum  = (AW + 1)'(fp_ff) + (AW + 1)'(count_ff);
   assign tail_addr = (tail_sum >= (AW + 1)'(DEPTH)) ? AW'(tail_sum - (AW + 1)'(DEPTH))
                                                     : AW'(tail_sum);
   assign fp_dec    = (fp_ff == '0) ? AW'(DEPTH - 1) : fp_ff - AW'(1);

   // operation decode and next state
   always_comb begin
      fp_in    = fp_ff;
      count_in = count_ff;
      front_in = front_ff;
      status   = bdq_pkg::ST_OK;
      wr_req   = 1'b0;
      wr_addr  = tail_addr;
      case (bdq_pkg::op_type'(op))
         bdq_pkg::OP_PUSH_BACK: begin
            if (full) begin
               status = bdq_pkg::ST_REJECTED;
            end else begin
               wr_req   = 1'b1;
               count_in = count_ff + CW'(1);
               if (count_ff == '0) begin
                  front_in = word;
               end
            end
         end
         bdq_pkg::OP_PUSH_FRONT: begin
            // when full the back entry is dropped, so the count holds
            if (full) begin
               status = bdq_pkg::ST_EVICTED;
            end else begin
               count_in = count_ff + CW'(1);
            end
            wr_req   = 1'b1;
            wr_addr  = fp_dec;
            fp_in    = fp_dec;
            front_in = word;
         end
         bdq_pkg::OP_POP_FRONT: begin
            if (count_ff == '0) begin
               status = bdq_pkg::ST_EMPTY;
            end else begin
               fp_in    = ring_inc(fp_ff);
               count_in = count_ff - CW'(1);
               front_in = next_word;
            end
         end
         bdq_pkg::OP_POP_BACK: begin
            if (count_ff == '0) begin
               status = bdq_pkg::ST_EMPTY;
            end else begin
               count_in = count_ff - CW'(1);
            end
         end
         default: begin
            // query and unused codes leave the state alone
         end
      endcase
   end

   // keep the entry behind the head prefetched for a front pop
   assign rd_addr = ring_inc(take ? fp_in : fp_ff);

   bdq_store #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (take && wr_req),
      .wr_addr (wr_addr),
      .wr_data (word),
      .rd_addr (rd_addr),
      .rd_data (next_word)
   );

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fp_ff    <= '0;
         count_ff <= '0;
      end else if (take) begin
         fp_ff    <= fp_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         front_ff <= front_in;
      end
   end

   // response fields after the step
   always_comb begin
      result.status     = status;
      result.front_data = (count_in == '0) ? '0 : bdq_pkg::DATA_W'(front_in);
      result.count      = bdq_pkg::COUNT_W'(count_in);
      result.is_empty   = (count_in == '0);
      result.is_full    = (count_in >= limit);
   end

endmodule

`default_nettype wire

// ----- rtl/bounded_deque_with_priority_push.sv -----
// Bounded deque with priority push.
// req channel: one operation per transfer (push back, priority push front,
//   pop front, pop back, query) with a data word.
// rsp channel: exactly one response per request, in order: status, front
//   word, entry count, empty and full flags, all as they stand after the step.
// csr channel: writes the capacity register (always ready); write it only
//   while no request is in flight. Values 0 and above DEPTH are clamped.
// Path: an accepted request passes the input register, the engine and the
//   result register, which drives rsp.
// Throughput: one request per cycle unless rsp stalls; the ring pointer,
//   count and one store port update together, next-to-front word prefetched.
// Reset empties the queue and sets the capacity to 100; store contents are
//   not cleared and are never visible.
// When rsp_tready is low the response is held and one more request is
//   buffered in the input register, after which req_tready drops.
`default_nettype none

module bounded_deque_with_priority_push #(
   parameter int DEPTH      = 128,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // req_tdata: [2:0] op, [34:3] data, [39:35] zero
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [bdq_pkg::REQ_W-1:0]   req_tdata,
   // rsp_tdata: [1:0] status, [33:2] front_data, [41:34] count,
   //            [42] is_empty, [43] is_full, [47:44] zero
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [bdq_pkg::RSP_W-1:0]        rsp_tdata,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [bdq_pkg::CAP_W-1:0]   csr_data
);

   logic                          in_valid_ff, in_valid_in;
   logic [bdq_pkg::OP_W-1:0]      in_op_ff;
   logic [bdq_pkg::DATA_W-1:0]    in_data_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   bdq_pkg::result_type           rsp_ff;
   bdq_pkg::result_type           result;
   logic [bdq_pkg::CAP_W-1:0]     cap_ff;
   logic                          req_take;
   logic                          advance;

   // capacity register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= bdq_pkg::CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         cap_ff <= csr_data;
      end
   end

   // handshake control
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff   <= req_tdata[bdq_pkg::OP_W-1:0];
         in_data_ff <= req_tdata[bdq_pkg::OP_W +: bdq_pkg::DATA_W];
      end
   end

   bdq_engine #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .take     (advance),
      .op       (in_op_ff),
      .data     (in_data_ff),
      .capacity (cap_ff),
      .result   (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_ff.is_full, rsp_ff.is_empty, rsp_ff.count,
                        rsp_ff.front_data, rsp_ff.status};

endmodule

`default_nettype wire

// ----- rtl/bdq_checker.sv -----
`default_nettype none

`include "bounded_deque_with_priority_push_macros.svh"

// Port-level checks on the response channel
module bdq_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       rsp_tvalid,
   input wire logic                       rsp_tready,
   input wire logic [bdq_pkg::RSP_W-1:0]  rsp_tdata
);

   logic [1:0] status;
   logic       empty;
   logic       full;
   logic       push_failed;
   logic       pop_failed;
   logic       stalled;

   assign status = rsp_tdata[1:0];
   assign empty  = rsp_tdata[42];
   assign full   = rsp_tdata[43];

   // rejected or evicting push, and pop on an empty queue
   assign push_failed = (status == bdq_pkg::ST_REJECTED) || (status == bdq_pkg::ST_EVICTED);
   assign pop_failed  = (status == bdq_pkg::ST_EMPTY);
   assign stalled     = rsp_tvalid && !rsp_tready;

   // an empty queue reports no entries and a zero front word
   `BDQ_ASSERT_NOW(a_empty_zero, rsp_tvalid && empty, (rsp_tdata[41:2] == '0), "empty with data")

   // capacity is at least one, so never both empty and full
   `BDQ_ASSERT_NOW(a_not_both, rsp_tvalid, !(empty && full), "empty and full together")

   // rejected or evicting pushes leave the queue full
   `BDQ_ASSERT_NOW(a_push_full, rsp_tvalid && push_failed, full, "failed push but not full")

   // a failed pop leaves it empty
   `BDQ_ASSERT_NOW(a_pop_empty, rsp_tvalid && pop_failed, empty, "failed pop but not empty")

   // a stalled response holds
   `BDQ_ASSERT_NEXT(a_rsp_hold, stalled, rsp_tvalid && $stable(rsp_tdata), "stall not held")

endmodule

bind bounded_deque_with_priority_push bdq_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ----- tb/bounded_deque_with_priority_push_tb.sv -----
`timescale 1ns / 1ps

module bounded_deque_with_priority_push_tb;

   localparam int DEPTH       = 128;
   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_REPORTS = 10;
   localparam int RES_W       = $bits(bdq_pkg::result_type);

   // op codes the block does not define; they behave as a query
   localparam logic [bdq_pkg::OP_W-1:0] OP_UNUSED_LO = 3'd5;
   localparam logic [bdq_pkg::OP_W-1:0] OP_UNUSED_HI = 3'd7;

   logic                        clock;
   logic                        reset;
   logic                        req_tvalid;
   logic                        req_tready;
   logic [bdq_pkg::REQ_W-1:0]   req_tdata;
   logic                        rsp_tvalid;
   logic                        rsp_tready;
   logic [bdq_pkg::RSP_W-1:0]   rsp_tdata;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [bdq_pkg::CAP_W-1:0]   csr_data;

   // shadow of the deque
   logic [bdq_pkg::DATA_W-1:0]  ring_words [DEPTH];
   int                          ring_head = 0;
   int                          ring_fill = 0;
   logic [bdq_pkg::CAP_W-1:0]   capacity_shadow = bdq_pkg::CAP_RESET;

   bdq_pkg::result_type         pending_results [$];
   int                          mismatches = 0;
   int                          send_idle_pct = 0;
   int                          rcv_idle_pct = 0;
   int                          rsp_hold_left = 0;
   int                          cycle_count = 0;

   bounded_deque_with_priority_push #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (bdq_pkg::DATA_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("bounded_deque_with_priority_push_tb failed");
         $finish;
      end
   end

   // capacity with zero and oversize values clamped
   function automatic int usable_capacity();
      if (capacity_shadow == 0)
         return 1;
      if (int'(capacity_shadow) > DEPTH)
         return DEPTH;
      return int'(capacity_shadow);
   endfunction

   // apply one operation to the shadow deque and return the response it gives
   function automatic bdq_pkg::result_type apply_deque_op(
         input logic [bdq_pkg::OP_W-1:0] op, input logic [bdq_pkg::DATA_W-1:0] word);
      bdq_pkg::result_type res;
      bit                  full;
      full = (ring_fill >= usable_capacity());
      res.status = bdq_pkg::ST_OK;
      case (op)
         bdq_pkg::OP_PUSH_BACK: begin
            if (full) begin
               res.status = bdq_pkg::ST_REJECTED;
            end else begin
               ring_words[(ring_head + ring_fill) % DEPTH] = word;
               ring_fill++;
            end
         end
         bdq_pkg::OP_PUSH_FRONT: begin
            // full: the back entry goes first
            if (full) begin
               ring_fill--;
               res.status = bdq_pkg::ST_EVICTED;
            end
            ring_head = (ring_head + DEPTH - 1) % DEPTH;
            ring_words[ring_head] = word;
            ring_fill++;
         end
         bdq_pkg::OP_POP_FRONT: begin
            if (ring_fill == 0) begin
               res.status = bdq_pkg::ST_EMPTY;
            end else begin
               ring_head = (ring_head + 1) % DEPTH;
               ring_fill--;
            end
         end
         bdq_pkg::OP_POP_BACK: begin
            if (ring_fill == 0)
               res.status = bdq_pkg::ST_EMPTY;
            else
               ring_fill--;
         end
         default: ;
      endcase
      res.front_data = (ring_fill == 0) ? '0 : ring_words[ring_head];
      res.count      = ring_fill[bdq_pkg::COUNT_W-1:0];
      res.is_empty   = (ring_fill == 0);
      res.is_full    = (ring_fill >= usable_capacity());
      return res;
   endfunction

   function automatic void note_fault(input string what, input bdq_pkg::result_type want,
                                      input bdq_pkg::result_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display({"%0t: %s: expected st=%0d front=%h cnt=%0d e=%0b f=%0b,",
                   " got st=%0d front=%h cnt=%0d e=%0b f=%0b"},
                  $realtime, what, want.status, want.front_data, want.count,
                  want.is_empty, want.is_full, got.status, got.front_data, got.count,
                  got.is_empty, got.is_full);
   endfunction

   // response checker
   always @(posedge clock) begin : check_rsp
      bdq_pkg::result_type got;
      bdq_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[RES_W-1:0];
         if (pending_results.size() == 0) begin
            note_fault("response with none expected", '0, got);
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status)
               note_fault("status", want, got);
            else if (got.front_data !== want.front_data)
               note_fault("front_data", want, got);
            else if (got.count !== want.count)
               note_fault("count", want, got);
            else if (got.is_empty !== want.is_empty)
               note_fault("is_empty", want, got);
            else if (got.is_full !== want.is_full)
               note_fault("is_full", want, got);
         end
      end
   end

   // response side: random stalls, plus a long hold when asked
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   // one request transfer; entered and left at a falling edge, valid left high
   task automatic send_req(input logic [bdq_pkg::OP_W-1:0] op,
                           input logic [bdq_pkg::DATA_W-1:0] word);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(bdq_pkg::REQ_W - bdq_pkg::OP_W - bdq_pkg::DATA_W){1'b0}}, word, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(apply_deque_op(op, word));
      @(negedge clock);
   endtask

   // stop offering and wait for every outstanding response
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [bdq_pkg::CAP_W-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      capacity_shadow = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [bdq_pkg::DATA_W-1:0] pick_word();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   // pops and queries on an empty deque, unused op codes
   task automatic test_empty_queue();
      send_req(bdq_pkg::OP_QUERY, '1);
      send_req(bdq_pkg::OP_POP_FRONT, pick_word());
      send_req(bdq_pkg::OP_POP_BACK, pick_word());
      send_req(OP_UNUSED_HI, '1);
      send_req(OP_UNUSED_LO, '0);
   endtask

   // fill to a small capacity, reject at the back, evict with a front push
   task automatic test_fill_and_evict();
      write_capacity(8'd3);
      send_req(bdq_pkg::OP_PUSH_BACK, '0);
      send_req(bdq_pkg::OP_PUSH_BACK, '1);
      send_req(bdq_pkg::OP_PUSH_FRONT, 32'hA5A5_A5A5);
      send_req(bdq_pkg::OP_PUSH_BACK, 32'h1234_5678);
      send_req(bdq_pkg::OP_PUSH_FRONT, 32'h5A5A_5A5A);
      send_req(bdq_pkg::OP_POP_BACK, '0);
      send_req(bdq_pkg::OP_POP_FRONT, '1);
      send_req(bdq_pkg::OP_QUERY, '0);
   endtask

   // capacity dropped under the count, then zero capacity
   task automatic test_capacity_clamp();
      send_req(bdq_pkg::OP_PUSH_BACK, 32'hDEAD_0001);
      send_req(bdq_pkg::OP_PUSH_BACK, 32'hDEAD_0002);
      write_capacity(8'd1);
      send_req(bdq_pkg::OP_PUSH_BACK, 32'hDEAD_0003);
      send_req(bdq_pkg::OP_PUSH_FRONT, 32'hDEAD_0004);
      send_req(bdq_pkg::OP_POP_FRONT, '0);
      send_req(bdq_pkg::OP_POP_BACK, '0);
      send_req(bdq_pkg::OP_POP_BACK, '0);
      write_capacity(8'd0);
      send_req(bdq_pkg::OP_PUSH_BACK, 32'hC0DE_0001);
      send_req(bdq_pkg::OP_PUSH_BACK, 32'hC0DE_0002);
      send_req(bdq_pkg::OP_PUSH_FRONT, 32'hC0DE_0003);
      send_req(bdq_pkg::OP_POP_FRONT, '0);
   endtask

   // random traffic at one capacity; push_pct steers the fill level
   task automatic run_random_phase(input logic [bdq_pkg::CAP_W-1:0] cap, input int n_items,
                                   input int push_pct);
      logic [bdq_pkg::OP_W-1:0] op;
      int                       pick;
      write_capacity(cap);
      repeat (n_items) begin
         if ($urandom_range(99) < push_pct) begin
            op = $urandom_range(1) ? bdq_pkg::OP_PUSH_FRONT : bdq_pkg::OP_PUSH_BACK;
         end else begin
            pick = $urandom_range(99);
            if (pick < 42)
               op = bdq_pkg::OP_POP_FRONT;
            else if (pick < 84)
               op = bdq_pkg::OP_POP_BACK;
            else if (pick < 96)
               op = bdq_pkg::OP_QUERY;
            else
               op = bdq_pkg::OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
         end
         send_req(op, pick_word());
      end
   endtask

   // long receiver hold while requests keep coming, so the input stalls
   task automatic test_backpressure();
      rsp_hold_left = 80;
      repeat (24) send_req(bdq_pkg::OP_PUSH_FRONT, pick_word());
      wait_idle();
      rsp_hold_left = 60;
      repeat (24)
         send_req($urandom_range(1) ? bdq_pkg::OP_POP_BACK : bdq_pkg::OP_PUSH_BACK,
                  pick_word());
      wait_idle();
   endtask

   task automatic test_random_traffic();
      // sender mostly busy, receiver often stalled
      send_idle_pct = 10;
      rcv_idle_pct  = 69;
      run_random_phase(8'd4, 200, 55);
      run_random_phase(8'd1, 100, 50);
      run_random_phase(8'd17, 200, 60);
      test_backpressure();
      // and the other way round
      send_idle_pct = 69;
      rcv_idle_pct  = 10;
      run_random_phase(8'd0, 100, 50);
      run_random_phase(8'd255, 250, 80);
      run_random_phase(8'd9, 150, 45);
      // back to back
      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      run_random_phase(8'd100, 250, 80);
      run_random_phase(8'($urandom_range(DEPTH, 1)), 200, 60);
      run_random_phase(8'(DEPTH), 300, 70);
      wait_idle();
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_queue();
      test_fill_and_evict();
      test_capacity_clamp();
      test_random_traffic();

      repeat (20) @(negedge clock);
      if (pending_results.size() != 0)
         mismatches++;
      if (mismatches == 0)
         $display("bounded_deque_with_priority_push_tb passed");
      else
         $display("bounded_deque_with_priority_push_tb failed");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/bdq_pkg.sv
rtl/bdq_store.sv
rtl/bdq_engine.sv
rtl/bounded_deque_with_priority_push.sv
rtl/bdq_checker.sv
tb/bounded_deque_with_priority_push_tb.sv
